// ===== rtl/eig_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package eig_pkg;

   // field widths
   localparam int DATA_W  = 32;
   localparam int TOL_W   = 16;
   localparam int VEC_W   = 35;
   localparam int NORM_W  = 31;

   // square root unit: radicand and root widths, one root bit per stage
   localparam int RAD_W   = 66;
   localparam int ROOT_W  = 33;
   localparam int ISQ_LAT = ROOT_W;

   // quotient bits of the unit-vector divider, one per stage
   localparam int DIV_STEPS = 31;

   // msb position of a normalized component
   localparam logic [5:0] NORM_MSB = 6'd30;

   localparam logic signed [DATA_W-1:0] Q30_ONE = 32'sh4000_0000;
   localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7fff_ffff;
   localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

   // status codes
   localparam logic [1:0] STAT_OK   = 2'd0;
   localparam logic [1:0] STAT_CPLX = 2'd1;
   localparam logic [1:0] STAT_ZERO = 2'd2;

   typedef struct packed {
      logic signed [DATA_W-1:0] e00;
      logic signed [DATA_W-1:0] e01;
      logic signed [DATA_W-1:0] e10;
      logic signed [DATA_W-1:0] e11;
   } mat_type;

   // front half side data
   typedef struct packed {
      mat_type             mat;
      logic signed [32:0]  trace;
      logic                cplx;
   } fr_type;

   // per-item data common to both eigenvector lanes
   typedef struct packed {
      logic signed [33:0]  lmaj;
      logic signed [33:0]  lmin;
      logic                cplx;
   } cm_type;

   // per-eigenvector lane data
   typedef struct packed {
      logic              sx;
      logic              sy;
      logic              diag;
      logic              dx;
      logic              zero;
      logic [NORM_W-1:0] nx;
      logic [NORM_W-1:0] ny;
   } ln_type;

   // magnitude of a sign-extended vector value
   function automatic logic [VEC_W-1:0] mag35(input logic signed [VEC_W-1:0] v);
      logic [VEC_W-1:0] r;
      r = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/eigen_2x2_solver.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Closed-form eigen solver for a 2x2 real matrix in signed Q15.16.
// Input: drive the four entries on req_entry_* and pulse start; a word is
//   taken at every rising edge with start high and busy low. busy is high
//   only during reset, so one matrix can be taken every cycle.
// Output: for each word taken, rsp_strobe is high for one cycle with both
//   eigenvalues (saturated), the two unit eigenvectors in Q2.30 and a status
//   (ok, complex eigenvalues, zero-length vector); values and vectors are
//   zero unless it is ok. Results leave in input order, one per cycle at
//   most; the receiver cannot hold them off and the pipeline never stalls.
// The datapath holds three bit-serial pipelines: the 33-stage square root
//   of the discriminant, the 33-stage root of each vector's squared length
//   and the 31-stage divider that scales each component to unit length,
//   plus twelve stages of arithmetic and output registers around them.
// Config: csr_data is written on csr_valid (csr_ready is always high) and
//   sets the zero tolerance; write it only while no word is in flight.
// Reset: synchronous; clears the tolerance to zero and drops every word
//   in flight.
module eigen_2x2_solver import eig_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     start,
   output logic                          busy,
   input  wire logic signed [DATA_W-1:0] req_entry_00,
   input  wire logic signed [DATA_W-1:0] req_entry_01,
   input  wire logic signed [DATA_W-1:0] req_entry_10,
   input  wire logic signed [DATA_W-1:0] req_entry_11,
   output logic                          rsp_strobe,
   output logic signed [DATA_W-1:0]      rsp_lambda_major,
   output logic signed [DATA_W-1:0]      rsp_lambda_minor,
   output logic signed [DATA_W-1:0]      rsp_major_vec_x,
   output logic signed [DATA_W-1:0]      rsp_major_vec_y,
   output logic signed [DATA_W-1:0]      rsp_minor_vec_x,
   output logic signed [DATA_W-1:0]      rsp_minor_vec_y,
   output logic [1:0]                    rsp_status,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [TOL_W-1:0]         csr_data
);

   localparam int PIPE_LAT = 4 + ISQ_LAT + 7 + ISQ_LAT + DIV_STEPS + 1;

   // tolerance register
   logic [TOL_W-1:0] tol_ff;
   logic [VEC_W-1:0] tol35;

   assign csr_ready = 1'b1;
   assign busy      = reset;
   assign tol35     = {{(VEC_W-TOL_W){1'b0}}, tol_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_data;
      end
   end

   // valid bits
   logic vld_ff [PIPE_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_LAT-1; i++) vld_ff[i] <= 1'b0;
      end else begin
         vld_ff[0] <= start && !busy;
         for (int i = 1; i < PIPE_LAT-1; i++) vld_ff[i] <= vld_ff[i-1];
      end
   end

   // stage 1: capture
   mat_type mat1_ff;

   always_ff @(posedge clock) begin
      mat1_ff.e00 <= req_entry_00;
      mat1_ff.e01 <= req_entry_01;
      mat1_ff.e10 <= req_entry_10;
      mat1_ff.e11 <= req_entry_11;
   end

   // stage 2: trace, diagonal difference, off-diagonal magnitudes
   mat_type            mat2_ff;
   logic signed [32:0] trace2_ff, diff2_in;
   logic [32:0]        dmag2_ff;
   logic [31:0]        bmag2_ff, cmag2_ff;
   logic               neg2_ff;

   assign diff2_in = {mat1_ff.e00[31], mat1_ff.e00} - {mat1_ff.e11[31], mat1_ff.e11};

   always_ff @(posedge clock) begin
      mat2_ff   <= mat1_ff;
      trace2_ff <= {mat1_ff.e00[31], mat1_ff.e00} + {mat1_ff.e11[31], mat1_ff.e11};
      dmag2_ff  <= diff2_in[32] ? 33'(-diff2_in) : 33'(diff2_in);
      bmag2_ff  <= mat1_ff.e01[31] ? 32'(-mat1_ff.e01) : 32'(mat1_ff.e01);
      cmag2_ff  <= mat1_ff.e10[31] ? 32'(-mat1_ff.e10) : 32'(mat1_ff.e10);
      neg2_ff   <= (mat1_ff.e01 != '0) && (mat1_ff.e10 != '0) &&
                   (mat1_ff.e01[31] ^ mat1_ff.e10[31]);
   end

   // stage 3: square of the diagonal difference and off-diagonal product
   mat_type            mat3_ff;
   logic signed [32:0] trace3_ff;
   logic [65:0]        sq3_ff;
   logic [63:0]        p3_ff;
   logic               neg3_ff;

   always_ff @(posedge clock) begin
      mat3_ff   <= mat2_ff;
      trace3_ff <= trace2_ff;
      sq3_ff    <= 66'(dmag2_ff) * 66'(dmag2_ff);
      p3_ff     <= 64'(bmag2_ff) * 64'(cmag2_ff);
      neg3_ff   <= neg2_ff;
   end

   // stage 4: discriminant and complex check
   logic [RAD_W-1:0] p4_in;
   logic [RAD_W-1:0] rad4_ff;
   fr_type           fr4_ff;

   assign p4_in = {p3_ff, 2'b00};

   always_ff @(posedge clock) begin
      fr4_ff.mat   <= mat3_ff;
      fr4_ff.trace <= trace3_ff;
      if (!neg3_ff) begin
         rad4_ff     <= sq3_ff + p4_in;
         fr4_ff.cplx <= 1'b0;
      end else if (p4_in > sq3_ff) begin
         rad4_ff     <= '0;
         fr4_ff.cplx <= 1'b1;
      end else begin
         rad4_ff     <= sq3_ff - p4_in;
         fr4_ff.cplx <= 1'b0;
      end
   end

   // root of the discriminant
   logic [ROOT_W-1:0] root_d;
   fr_type            fr_dly_ff [ISQ_LAT];

   eig_isqrt u_isqrt_disc (
      .clock (clock),
      .rad   (rad4_ff),
      .root  (root_d)
   );

   always_ff @(posedge clock) begin
      fr_dly_ff[0] <= fr4_ff;
      for (int i = 1; i < ISQ_LAT; i++) fr_dly_ff[i] <= fr_dly_ff[i-1];
   end

   // stage 5: eigenvalues, floor of half the sum and difference
   fr_type             fr5_in;
   logic signed [34:0] smaj5_in, smin5_in;
   mat_type            mat5_ff;
   cm_type             cm5_ff;

   assign fr5_in   = fr_dly_ff[ISQ_LAT-1];
   assign smaj5_in = {{2{fr5_in.trace[32]}}, fr5_in.trace} + {2'b00, root_d};
   assign smin5_in = {{2{fr5_in.trace[32]}}, fr5_in.trace} - {2'b00, root_d};

   always_ff @(posedge clock) begin
      mat5_ff     <= fr5_in.mat;
      cm5_ff.lmaj <= smaj5_in[34:1];
      cm5_ff.lmin <= smin5_in[34:1];
      cm5_ff.cplx <= fr5_in.cplx;
   end

   // stage 6: build the raw vector for each eigenvalue
   logic signed [VEC_W-1:0] ea, eb, ec, ed;
   logic                    bbig, cbig;
   logic signed [VEC_W-1:0] lam6 [2];
   logic signed [VEC_W-1:0] xa6 [2];
   logic signed [VEC_W-1:0] xd6 [2];
   logic signed [VEC_W-1:0] x6_ff [2];
   logic signed [VEC_W-1:0] y6_ff [2];
   logic                    diag6_ff [2];
   logic                    dx6_ff [2];
   cm_type                  cm6_ff;

   assign ea   = {{3{mat5_ff.e00[31]}}, mat5_ff.e00};
   assign eb   = {{3{mat5_ff.e01[31]}}, mat5_ff.e01};
   assign ec   = {{3{mat5_ff.e10[31]}}, mat5_ff.e10};
   assign ed   = {{3{mat5_ff.e11[31]}}, mat5_ff.e11};
   assign bbig = mag35(eb) > tol35;
   assign cbig = mag35(ec) > tol35;

   always_comb begin
      lam6[0] = {cm5_ff.lmaj[33], cm5_ff.lmaj};
      lam6[1] = {cm5_ff.lmin[33], cm5_ff.lmin};
      for (int j = 0; j < 2; j++) begin
         xa6[j] = lam6[j] - ea;
         xd6[j] = lam6[j] - ed;
      end
   end

   always_ff @(posedge clock) begin
      cm6_ff <= cm5_ff;
      for (int j = 0; j < 2; j++) begin
         dx6_ff[j] <= mag35(xa6[j]) <= tol35;
         if (bbig) begin
            x6_ff[j]    <= xd6[j];
            y6_ff[j]    <= eb;
            diag6_ff[j] <= 1'b0;
         end else if (cbig) begin
            x6_ff[j]    <= ec;
            y6_ff[j]    <= xa6[j];
            diag6_ff[j] <= 1'b0;
         end else begin
            x6_ff[j]    <= ec;
            y6_ff[j]    <= eb;
            diag6_ff[j] <= 1'b1;
         end
      end
   end

   // stage 7: magnitudes, signs, larger magnitude
   logic [VEC_W-1:0] mx7_in [2];
   logic [VEC_W-1:0] my7_in [2];
   logic [VEC_W-1:0] mx7_ff [2];
   logic [VEC_W-1:0] my7_ff [2];
   logic [VEC_W-1:0] m7_ff [2];
   logic             sx7_ff [2];
   logic             sy7_ff [2];
   logic             diag7_ff [2];
   logic             dx7_ff [2];
   cm_type           cm7_ff;

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         mx7_in[j] = mag35(x6_ff[j]);
         my7_in[j] = mag35(y6_ff[j]);
      end
   end

   always_ff @(posedge clock) begin
      cm7_ff <= cm6_ff;
      for (int j = 0; j < 2; j++) begin
         mx7_ff[j]   <= mx7_in[j];
         my7_ff[j]   <= my7_in[j];
         m7_ff[j]    <= (mx7_in[j] > my7_in[j]) ? mx7_in[j] : my7_in[j];
         sx7_ff[j]   <= x6_ff[j][VEC_W-1];
         sy7_ff[j]   <= y6_ff[j][VEC_W-1];
         diag7_ff[j] <= diag6_ff[j];
         dx7_ff[j]   <= dx6_ff[j];
      end
   end

   // stage 8: zero-length test and leading one of the larger magnitude
   logic [32:0]      len8_in [2];
   logic [5:0]       pos8_in [2];
   logic [31:0]      tol_sq;
   logic [VEC_W-1:0] mx8_ff [2];
   logic [VEC_W-1:0] my8_ff [2];
   logic [5:0]       pos8_ff [2];
   logic             zero8_ff [2];
   logic             sx8_ff [2];
   logic             sy8_ff [2];
   logic             diag8_ff [2];
   logic             dx8_ff [2];
   cm_type           cm8_ff;

   assign tol_sq = 32'(tol_ff) * 32'(tol_ff);

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         len8_in[j] = 33'(mx7_ff[j][15:0] * mx7_ff[j][15:0]) +
                      33'(my7_ff[j][15:0] * my7_ff[j][15:0]);
         pos8_in[j] = '0;
         for (int i = 0; i < VEC_W; i++) begin
            if (m7_ff[j][i]) pos8_in[j] = 6'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      cm8_ff <= cm7_ff;
      for (int j = 0; j < 2; j++) begin
         mx8_ff[j]   <= mx7_ff[j];
         my8_ff[j]   <= my7_ff[j];
         pos8_ff[j]  <= pos8_in[j];
         zero8_ff[j] <= !diag7_ff[j] && (m7_ff[j] <= tol35) &&
                        (len8_in[j] <= {1'b0, tol_sq});
         sx8_ff[j]   <= sx7_ff[j];
         sy8_ff[j]   <= sy7_ff[j];
         diag8_ff[j] <= diag7_ff[j];
         dx8_ff[j]   <= dx7_ff[j];
      end
   end

   // stage 9: normalize so the larger magnitude has its msb at bit 30
   logic [5:0] shl9 [2];
   logic [5:0] shr9 [2];
   ln_type     ln9_ff [2];
   cm_type     cm9_ff;

   always_comb begin
      for (int j = 0; j < 2; j++) begin
         shl9[j] = NORM_MSB - pos8_ff[j];
         shr9[j] = pos8_ff[j] - NORM_MSB;
      end
   end

   always_ff @(posedge clock) begin
      cm9_ff <= cm8_ff;
      for (int j = 0; j < 2; j++) begin
         if (pos8_ff[j] < NORM_MSB) begin
            ln9_ff[j].nx <= NORM_W'(mx8_ff[j] << shl9[j]);
            ln9_ff[j].ny <= NORM_W'(my8_ff[j] << shl9[j]);
         end else begin
            ln9_ff[j].nx <= NORM_W'(mx8_ff[j] >> shr9[j]);
            ln9_ff[j].ny <= NORM_W'(my8_ff[j] >> shr9[j]);
         end
         ln9_ff[j].sx   <= sx8_ff[j];
         ln9_ff[j].sy   <= sy8_ff[j];
         ln9_ff[j].diag <= diag8_ff[j];
         ln9_ff[j].dx   <= dx8_ff[j];
         ln9_ff[j].zero <= zero8_ff[j];
      end
   end

   // stage 10: component squares
   logic [61:0] sqx10_ff [2];
   logic [61:0] sqy10_ff [2];
   ln_type      ln10_ff [2];
   cm_type      cm10_ff;

   always_ff @(posedge clock) begin
      cm10_ff <= cm9_ff;
      for (int j = 0; j < 2; j++) begin
         sqx10_ff[j] <= 62'(ln9_ff[j].nx) * 62'(ln9_ff[j].nx);
         sqy10_ff[j] <= 62'(ln9_ff[j].ny) * 62'(ln9_ff[j].ny);
         ln10_ff[j]  <= ln9_ff[j];
      end
   end

   // stage 11: squared length
   logic [RAD_W-1:0] len11_ff [2];
   ln_type           ln11_ff [2];
   cm_type           cm11_ff;

   always_ff @(posedge clock) begin
      cm11_ff <= cm10_ff;
      for (int j = 0; j < 2; j++) begin
         len11_ff[j] <= RAD_W'(sqx10_ff[j]) + RAD_W'(sqy10_ff[j]);
         ln11_ff[j]  <= ln10_ff[j];
      end
   end

   // vector lengths
   logic [ROOT_W-1:0] vroot [2];
   ln_type            ln_dly_ff [ISQ_LAT][2];
   cm_type            cm_dly_ff [ISQ_LAT];

   for (genvar j = 0; j < 2; j++) begin : g_vlen
      eig_isqrt u_isqrt_len (
         .clock (clock),
         .rad   (len11_ff[j]),
         .root  (vroot[j])
      );
   end

   always_ff @(posedge clock) begin
      ln_dly_ff[0] <= ln11_ff;
      cm_dly_ff[0] <= cm11_ff;
      for (int i = 1; i < ISQ_LAT; i++) begin
         ln_dly_ff[i] <= ln_dly_ff[i-1];
         cm_dly_ff[i] <= cm_dly_ff[i-1];
      end
   end

   // dividers: component * 2^30 / length, lane = d/2, y component when d is odd
   logic [NORM_W-1:0] dm_in [4];
   logic [31:0]       drem_ff [4][DIV_STEPS];
   logic [31:0]       dr_ff [4][DIV_STEPS];
   logic [NORM_W-1:0] dq_ff [4][DIV_STEPS];
   ln_type            dln_ff [DIV_STEPS][2];
   cm_type            dcm_ff [DIV_STEPS];

   always_comb begin
      for (int d = 0; d < 4; d++) begin
         dm_in[d] = d[0] ? ln_dly_ff[ISQ_LAT-1][d/2].ny : ln_dly_ff[ISQ_LAT-1][d/2].nx;
      end
   end

   for (genvar d = 0; d < 4; d++) begin : g_div
      for (genvar s = 0; s < DIV_STEPS; s++) begin : g_step
         logic [31:0]       rem_in;
         logic [31:0]       r_in;
         logic [NORM_W-1:0] q_in;
         logic              bit_in;
         logic [32:0]       shift_rem;

         if (s == 0) begin : g_first
            assign rem_in = {2'b00, dm_in[d][NORM_W-1:1]};
            assign r_in   = vroot[d/2][31:0];
            assign q_in   = '0;
            assign bit_in = dm_in[d][0];
         end else begin : g_next
            assign rem_in = drem_ff[d][s-1];
            assign r_in   = dr_ff[d][s-1];
            assign q_in   = dq_ff[d][s-1];
            assign bit_in = 1'b0;
         end

         assign shift_rem = {rem_in, bit_in};

         always_ff @(posedge clock) begin
            dr_ff[d][s] <= r_in;
            if (shift_rem >= {1'b0, r_in}) begin
               drem_ff[d][s] <= 32'(shift_rem - {1'b0, r_in});
               dq_ff[d][s]   <= {q_in[NORM_W-2:0], 1'b1};
            end else begin
               drem_ff[d][s] <= shift_rem[31:0];
               dq_ff[d][s]   <= {q_in[NORM_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      dln_ff[0] <= ln_dly_ff[ISQ_LAT-1];
      dcm_ff[0] <= cm_dly_ff[ISQ_LAT-1];
      for (int i = 1; i < DIV_STEPS; i++) begin
         dln_ff[i] <= dln_ff[i-1];
         dcm_ff[i] <= dcm_ff[i-1];
      end
   end

   // output stage: signs, diagonal case, saturation, status
   ln_type                   lno [2];
   cm_type                   cmo;
   logic signed [DATA_W-1:0] qs [4];
   logic signed [DATA_W-1:0] vec [4];
   logic signed [DATA_W-1:0] lam_sat [2];
   logic signed [33:0]       lam_raw [2];
   logic [1:0]               status_in;

   assign cmo = dcm_ff[DIV_STEPS-1];

   always_comb begin
      lno[0]     = dln_ff[DIV_STEPS-1][0];
      lno[1]     = dln_ff[DIV_STEPS-1][1];
      lam_raw[0] = cmo.lmaj;
      lam_raw[1] = cmo.lmin;
      for (int d = 0; d < 4; d++) begin
         qs[d] = {1'b0, dq_ff[d][DIV_STEPS-1]};
         if (d[0] ? lno[d/2].sy : lno[d/2].sx) qs[d] = -qs[d];
         if (lno[d/2].diag) begin
            vec[d] = (lno[d/2].dx ^ d[0]) ? Q30_ONE : '0;
         end else begin
            vec[d] = qs[d];
         end
      end
      for (int j = 0; j < 2; j++) begin
         if (lam_raw[j] > 34'(SAT_MAX)) begin
            lam_sat[j] = SAT_MAX;
         end else if (lam_raw[j] < 34'(SAT_MIN)) begin
            lam_sat[j] = SAT_MIN;
         end else begin
            lam_sat[j] = lam_raw[j][DATA_W-1:0];
         end
      end
      if (cmo.cplx) begin
         status_in = STAT_CPLX;
      end else if (lno[0].zero || lno[1].zero) begin
         status_in = STAT_ZERO;
      end else begin
         status_in = STAT_OK;
      end
   end

   logic                     strobe_ff;
   logic signed [DATA_W-1:0] lmaj_ff, lmin_ff;
   logic signed [DATA_W-1:0] vec_ff [4];
   logic [1:0]               status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= vld_ff[PIPE_LAT-2];
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      if (status_in == STAT_OK) begin
         lmaj_ff <= lam_sat[0];
         lmin_ff <= lam_sat[1];
         for (int d = 0; d < 4; d++) vec_ff[d] <= vec[d];
      end else begin
         lmaj_ff <= '0;
         lmin_ff <= '0;
         for (int d = 0; d < 4; d++) vec_ff[d] <= '0;
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_lambda_major = lmaj_ff;
   assign rsp_lambda_minor = lmin_ff;
   assign rsp_major_vec_x  = vec_ff[0];
   assign rsp_major_vec_y  = vec_ff[1];
   assign rsp_minor_vec_x  = vec_ff[2];
   assign rsp_minor_vec_y  = vec_ff[3];
   assign rsp_status       = status_ff;

endmodule

`default_nettype wire

// ===== rtl/eig_isqrt.sv =====
`timescale 1ns / 1ps
`default_nettype none

// pipelined floor square root, one root bit per stage
module eig_isqrt import eig_pkg::*; (
   input  wire logic              clock,
   input  wire logic [RAD_W-1:0]  rad,
   output logic      [ROOT_W-1:0] root
);

   localparam int REM_W = ROOT_W + 2;

   logic [RAD_W-1:0]  rad_ff  [ROOT_W];
   logic [REM_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];

   for (genvar g = 0; g < ROOT_W; g++) begin : g_step
      logic [RAD_W-1:0]  rad_in;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [REM_W+1:0]  shift_rem;
      logic [REM_W+1:0]  trial;

      if (g == 0) begin : g_first
         assign rad_in  = rad;
         assign rem_in  = '0;
         assign root_in = '0;
      end else begin : g_next
         assign rad_in  = rad_ff[g-1];
         assign rem_in  = rem_ff[g-1];
         assign root_in = root_ff[g-1];
      end

      // bring down the next bit pair and try the odd trial value
      assign shift_rem = {rem_in, rad_in[RAD_W-1 -: 2]};
      assign trial     = {2'b00, root_in, 2'b01};

      always_ff @(posedge clock) begin
         rad_ff[g] <= rad_in << 2;
         if (shift_rem >= trial) begin
            rem_ff[g]  <= REM_W'(shift_rem - trial);
            root_ff[g] <= {root_in[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff[g]  <= shift_rem[REM_W-1:0];
            root_ff[g] <= {root_in[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign root = root_ff[ROOT_W-1];

endmodule

`default_nettype wire
